FILE: rtl/lus_pkg.sv
// Shared constants, types and helpers for the largest uniform square block.
// Used by largest_uniform_square, lus_checker and tb_top; depends on nothing else.
`timescale 1ns / 1ps

package lus_pkg;

    // Image size limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    // Prefix table geometry, zero border row and column included
    localparam int TBL_W     = MAX_COLS + 1;
    localparam int TBL_DEPTH = (MAX_ROWS + 1) * TBL_W;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    // Field and internal widths
    localparam int DIM_W   = 7;                                  // config and result field
    localparam int CRD_W   = $clog2(MAX_DIM + 2);                // coordinates, side + 1
    localparam int SUM_W   = $clog2(MAX_ROWS * MAX_COLS + 1);    // prefix sums
    localparam int RS_W    = $clog2(MAX_COLS + 1);               // running row sum
    localparam int CFG_I_W = 2;                                  // config register index

    // Config register indexes
    localparam logic [CFG_I_W-1:0] REG_NUM_ROWS = CFG_I_W'(0);
    localparam logic [CFG_I_W-1:0] REG_NUM_COLS = CFG_I_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,    // take pixels, build the prefix table
        ST_DRAIN,   // last table write completes
        ST_POS,     // pick the next corner with a side still worth testing
        ST_RD,      // issue the four corner reads of one window
        ST_WAIT,    // last corner read returns
        ST_CHK,     // test the window sum, advance side or corner
        ST_FIN      // hand the result to the output register
    } t_state;

    // Window corner read phases
    typedef enum logic [1:0] {
        PH_BR = 2'd0,   // bottom right, added
        PH_TR = 2'd1,   // top right, subtracted
        PH_BL = 2'd2,   // bottom left, subtracted
        PH_TL = 2'd3    // top left, added
    } t_phase;

    // Flat table address of (row, col)
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CRD_W-1:0] row,
                                                   input logic [CRD_W-1:0] col);
        tbl_addr = ADDR_W'(row) * ADDR_W'(TBL_W) + ADDR_W'(col);
    endfunction

    // Dimension in use: zero reads as one, anything above the limit as the limit
    function automatic logic [CRD_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [CRD_W-1:0] maxv);
        logic [CRD_W-1:0] res;
        res = maxv;
        if (v == '0) begin
            res = CRD_W'(1);
        end else if (int'(v) <= int'(maxv)) begin
            res = CRD_W'(v);
        end
        clamp_dim = res;
    endfunction

endpackage

FILE: rtl/lus_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; holds the prefix table of the largest uniform square block.
`timescale 1ns / 1ps

module lus_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4225
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/largest_uniform_square.sv
// Largest uniform square: finds the largest all-zero or all-one square in a binary image.
// Depends on lus_pkg and on lus_ram for the prefix-sum table.
//
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) sets num_rows
//   (index 0) and num_cols (index 1); a write restarts loading at the first pixel. It is
//   taken only while the block is loading pixels and goes ahead of a pixel offered in the
//   same cycle. Unknown indexes are dropped.
//   Input channel (i_in_valid / o_in_ready, i_pixel) takes one pixel per cycle in
//   raster order while loading and no config item waits. Each pixel does one table
//   read and, in the cycle after, one table write. After the last pixel of the image
//   the block searches the table and then offers one item on the output channel
//   (o_out_valid / i_out_ready, o_largest_side). Only sides above the best so far are
//   tested; each window needs four reads of the single table read port.
//   The result sits in an output register: loading of the next image goes on while the
//   receiver stalls, and only the end of the next search waits for that register.
//   Reset clears the sequencer, sets both dimensions to 64 and the best side to 1. The
//   table's zero border is produced by logic, so no clearing pass follows reset.
`timescale 1ns / 1ps

module largest_uniform_square (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lus_pkg::CFG_I_W-1:0]      i_cfg_index,
    input  logic [lus_pkg::DIM_W-1:0]        i_cfg_data,
    // pixel channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_pixel,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lus_pkg::DIM_W-1:0]        o_largest_side
);

    localparam int CRD_W  = lus_pkg::CRD_W;
    localparam int SUM_W  = lus_pkg::SUM_W;
    localparam int ADDR_W = lus_pkg::ADDR_W;
    localparam int RS_W   = lus_pkg::RS_W;
    localparam int DIM_W  = lus_pkg::DIM_W;
    localparam int SQ_W   = 2 * CRD_W;

    // State and config
    lus_pkg::t_state r_state, n_state;
    logic [DIM_W-1:0] r_num_rows, r_num_cols;
    logic [CRD_W-1:0] rows_eff, cols_eff;

    // Load side
    logic [CRD_W-1:0]  r_load_row, r_load_col;
    logic [RS_W-1:0]   r_rowsum;
    logic [CRD_W-1:0]  ld_r, ld_c, ld_c_nx, ld_r_nx;
    logic              ld_wrap, ld_last;
    logic [RS_W-1:0]   rs_new;
    logic [ADDR_W-1:0] ld_raddr;

    // Write stage of the load pipeline
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_waddr;
    logic [RS_W-1:0]   r_s1_rowsum;
    logic              r_s1_zero;
    logic              r_s1_fwd;
    logic [SUM_W-1:0]  r_fwd_data;
    logic [SUM_W-1:0]  s1_above, s1_wdata;

    // Search side
    logic [CRD_W-1:0]  r_sr, r_sc, r_k, r_best;
    lus_pkg::t_phase   r_ph, r_rd_ph;
    logic              r_rd_vld, r_rd_zero;
    logic [SUM_W-1:0]  r_acc, rd_val;
    logic [CRD_W-1:0]  lim, k_start, row_a, col_a, rd_row, rd_col;
    logic [CRD_W-1:0]  row_left, col_left;
    logic              pos_ok, pos_last, k_more, uni;
    logic [SQ_W-1:0]   k_sq;
    logic [ADDR_W-1:0] sr_raddr;

    // Output register
    logic             r_out_valid;
    logic [DIM_W-1:0] r_out_side;

    // Handshakes and control
    logic              in_acc, cfg_acc, cfg_hit, out_acc, out_free;
    logic              in_ready, cfg_ready, sr_re;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;

    assign rows_eff = lus_pkg::clamp_dim(r_num_rows, CRD_W'(lus_pkg::MAX_ROWS));
    assign cols_eff = lus_pkg::clamp_dim(r_num_cols, CRD_W'(lus_pkg::MAX_COLS));

    assign in_acc   = i_in_valid && in_ready;
    assign cfg_acc  = i_cfg_valid && cfg_ready;
    assign cfg_hit  = cfg_acc && ((i_cfg_index == lus_pkg::REG_NUM_ROWS) ||
                                  (i_cfg_index == lus_pkg::REG_NUM_COLS));
    assign out_acc  = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- load path
    // Restart from the first pixel if the position lies outside the image
    always_comb begin
        ld_r = r_load_row;
        ld_c = r_load_col;
        if ((r_load_row >= rows_eff) || (r_load_col >= cols_eff)) begin
            ld_r = '0;
            ld_c = '0;
        end
    end

    assign ld_c_nx  = ld_c + CRD_W'(1);
    assign ld_r_nx  = ld_r + CRD_W'(1);
    assign ld_wrap  = (ld_c_nx >= cols_eff);
    assign ld_last  = ld_wrap && (ld_r_nx >= rows_eff);
    assign rs_new   = ((ld_c == '0) ? '0 : r_rowsum) + RS_W'(i_pixel);
    assign ld_raddr = lus_pkg::tbl_addr(ld_r, ld_c_nx);

    // Entry above plus the running row sum; border and just-written entry bypass the RAM
    assign s1_above = r_s1_zero ? '0 : (r_s1_fwd ? r_fwd_data : ram_rdata);
    assign s1_wdata = s1_above + SUM_W'(r_s1_rowsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row <= '0;
            r_load_col <= '0;
            r_s1_vld   <= 1'b0;
            r_num_rows <= DIM_W'(64);
            r_num_cols <= DIM_W'(64);
        end else begin
            r_s1_vld <= in_acc;
            // Advance the raster position
            if (cfg_hit) begin
                r_load_row <= '0;
                r_load_col <= '0;
            end else if (in_acc) begin
                r_load_col <= ld_wrap ? '0 : ld_c_nx;
                r_load_row <= ld_last ? '0 : (ld_wrap ? ld_r_nx : ld_r);
            end
            // Config registers
            if (cfg_acc && (i_cfg_index == lus_pkg::REG_NUM_ROWS)) begin
                r_num_rows <= i_cfg_data;
            end
            if (cfg_acc && (i_cfg_index == lus_pkg::REG_NUM_COLS)) begin
                r_num_cols <= i_cfg_data;
            end
        end
    end

    // Payload of the write stage
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rowsum    <= rs_new;
            r_s1_waddr  <= lus_pkg::tbl_addr(ld_r_nx, ld_c_nx);
            r_s1_rowsum <= rs_new;
            r_s1_zero   <= (ld_r == '0);
            r_s1_fwd    <= r_s1_vld && (ld_raddr == r_s1_waddr);
            r_fwd_data  <= s1_wdata;
        end
    end

    // ---------------------------------------------------------------- search path
    assign row_left = rows_eff - r_sr;
    assign col_left = cols_eff - r_sc;
    assign lim      = (row_left < col_left) ? row_left : col_left;
    assign k_start  = r_best + CRD_W'(1);
    assign pos_ok   = (k_start <= lim);
    assign pos_last = ((r_sc + CRD_W'(1)) >= cols_eff) && ((r_sr + CRD_W'(1)) >= rows_eff);
    assign k_more   = (r_k < lim);
    assign k_sq     = SQ_W'(r_k) * SQ_W'(r_k);
    assign uni      = (r_acc == '0) || (SQ_W'(r_acc) == k_sq);

    assign row_a = r_sr + r_k;
    assign col_a = r_sc + r_k;

    // Pick the corner of the window for this read phase
    always_comb begin
        unique case (r_ph)
            lus_pkg::PH_BR: begin
                rd_row = row_a;
                rd_col = col_a;
            end
            lus_pkg::PH_TR: begin
                rd_row = r_sr;
                rd_col = col_a;
            end
            lus_pkg::PH_BL: begin
                rd_row = row_a;
                rd_col = r_sc;
            end
            lus_pkg::PH_TL: begin
                rd_row = r_sr;
                rd_col = r_sc;
            end
            default: begin
                rd_row = r_sr;
                rd_col = r_sc;
            end
        endcase
    end

    assign sr_raddr = lus_pkg::tbl_addr(rd_row, rd_col);
    assign rd_val   = r_rd_zero ? '0 : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_best   <= CRD_W'(1);
        end else begin
            r_rd_vld <= sr_re;
            // Start a new search after the last pixel
            if (in_acc && ld_last) begin
                r_best <= CRD_W'(1);
            end else if ((r_state == lus_pkg::ST_CHK) && uni) begin
                r_best <= r_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Track the read in flight
        r_rd_ph   <= r_ph;
        r_rd_zero <= (rd_row == '0) || (rd_col == '0);

        // Accumulate the window sum as corner reads return
        if (r_rd_vld) begin
            unique case (r_rd_ph)
                lus_pkg::PH_BR, lus_pkg::PH_TL: r_acc <= r_acc + rd_val;
                lus_pkg::PH_TR, lus_pkg::PH_BL: r_acc <= r_acc - rd_val;
                default:                         r_acc <= r_acc;
            endcase
        end

        unique case (r_state)
            lus_pkg::ST_LOAD: begin
                if (in_acc && ld_last) begin
                    r_sr <= '0;
                    r_sc <= '0;
                end
            end
            lus_pkg::ST_POS: begin
                if (pos_ok) begin
                    r_k   <= k_start;
                    r_ph  <= lus_pkg::PH_BR;
                    r_acc <= '0;
                end else if (!pos_last) begin
                    // Skip a corner whose room is no larger than the best side
                    if ((r_sc + CRD_W'(1)) >= cols_eff) begin
                        r_sc <= '0;
                        r_sr <= r_sr + CRD_W'(1);
                    end else begin
                        r_sc <= r_sc + CRD_W'(1);
                    end
                end
            end
            lus_pkg::ST_RD: begin
                r_ph <= lus_pkg::t_phase'(r_ph + 2'd1);
            end
            lus_pkg::ST_CHK: begin
                if (k_more) begin
                    r_k   <= r_k + CRD_W'(1);
                    r_ph  <= lus_pkg::PH_BR;
                    r_acc <= '0;
                end else if (!pos_last) begin
                    if ((r_sc + CRD_W'(1)) >= cols_eff) begin
                        r_sc <= '0;
                        r_sr <= r_sr + CRD_W'(1);
                    end else begin
                        r_sc <= r_sc + CRD_W'(1);
                    end
                end
            end
            default: begin
                r_sr <= r_sr;
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lus_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lus_pkg::ST_LOAD:  if (in_acc && ld_last) n_state = lus_pkg::ST_DRAIN;
            lus_pkg::ST_DRAIN: n_state = lus_pkg::ST_POS;
            lus_pkg::ST_POS: begin
                if (pos_ok) begin
                    n_state = lus_pkg::ST_RD;
                end else if (pos_last) begin
                    n_state = lus_pkg::ST_FIN;
                end
            end
            lus_pkg::ST_RD:    if (r_ph == lus_pkg::PH_TL) n_state = lus_pkg::ST_WAIT;
            lus_pkg::ST_WAIT:  n_state = lus_pkg::ST_CHK;
            lus_pkg::ST_CHK: begin
                if (k_more) begin
                    n_state = lus_pkg::ST_RD;
                end else if (pos_last) begin
                    n_state = lus_pkg::ST_FIN;
                end else begin
                    n_state = lus_pkg::ST_POS;
                end
            end
            lus_pkg::ST_FIN:   if (out_free) n_state = lus_pkg::ST_LOAD;
            default:           n_state = lus_pkg::ST_LOAD;
        endcase
    end

    // State outputs; a waiting config item goes ahead of the pixel
    always_comb begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        sr_re     = 1'b0;
        unique case (r_state)
            lus_pkg::ST_LOAD: begin
                in_ready  = !i_cfg_valid;
                cfg_ready = 1'b1;
            end
            lus_pkg::ST_RD: sr_re = 1'b1;
            default: begin
                sr_re = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == lus_pkg::ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lus_pkg::ST_FIN) && out_free) begin
            r_out_side <= DIM_W'(r_best);
        end
    end

    // ---------------------------------------------------------------- prefix table
    assign ram_re    = in_acc || sr_re;
    assign ram_raddr = sr_re ? sr_raddr : ld_raddr;

    lus_ram #(
        .WIDTH (SUM_W),
        .DEPTH (lus_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready     = in_ready;
    assign o_cfg_ready    = cfg_ready;
    assign o_out_valid    = r_out_valid;
    assign o_largest_side = r_out_side;

    // ---------------------------------------------------------------- assertions
    // Table writes from loading never collide with search reads
    a_no_wr_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> ((r_state == lus_pkg::ST_LOAD) || (r_state == lus_pkg::ST_DRAIN)))
        else $error("table write outside loading");

    // Every tested side beats the best side found so far and fits in the room at its corner
    a_side_above_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lus_pkg::ST_RD) |-> ((r_k > r_best) && (r_k <= lim)))
        else $error("tested side out of range");

    // The best side only grows during a search
    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lus_pkg::ST_CHK) |=> (r_best >= $past(r_best)))
        else $error("best side shrank");

    // A result handed over is at least one
    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_side != '0))
        else $error("zero result");

    // The result register is loaded only when free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lus_pkg::ST_FIN) && r_out_valid && !i_out_ready) |=>
            (r_state == lus_pkg::ST_FIN))
        else $error("result overwritten");

endmodule

FILE: bench/lus_checker.sv
`timescale 1ns / 1ps
// Scoreboard for largest_uniform_square: watches the config, pixel and result channels.
// It predicts the largest uniform side of each image and compares it with the block's item.
// Depends on lus_pkg for field widths and register indexes.

module lus_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lus_pkg::CFG_I_W-1:0]   i_cfg_index,
    input  logic [lus_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_pixel,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [lus_pkg::DIM_W-1:0]     i_largest_side,
    output int                            o_fail_count,
    output int                            o_pending
);

    // Register copies and raster position of the next pixel
    logic [lus_pkg::DIM_W-1:0] rows_reg;
    logic [lus_pkg::DIM_W-1:0] cols_reg;
    int unsigned               row_pos;
    int unsigned               col_pos;
    int unsigned               rows_used;
    int unsigned               cols_used;

    // Pixels of the image being loaded
    logic image [lus_pkg::MAX_ROWS][lus_pkg::MAX_COLS];

    // Sides still owed by the block, oldest first
    logic [lus_pkg::DIM_W-1:0] expected_sides [$];
    logic [lus_pkg::DIM_W-1:0] want;

    // Zero counts as one, anything past the limit as the limit
    function automatic int unsigned dim_in_use(input logic [lus_pkg::DIM_W-1:0] v,
                                               input int unsigned lim);
        if (v == '0) return 1;
        if (int'(v) > lim) return lim;
        return 32'(v);
    endfunction

    // Side of the largest single-valued square, by the run of equal squares ending at each pixel
    function automatic logic [lus_pkg::DIM_W-1:0] largest_square(input int unsigned rows,
                                                                 input int unsigned cols);
        int unsigned run [lus_pkg::MAX_ROWS][lus_pkg::MAX_COLS];
        int unsigned best;
        int unsigned m;
        best = 1;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                run[r][c] = 1;
                if (r > 0 && c > 0 && image[r][c] == image[r-1][c] &&
                        image[r][c] == image[r][c-1] && image[r][c] == image[r-1][c-1]) begin
                    m = run[r-1][c];
                    if (run[r][c-1] < m) m = run[r][c-1];
                    if (run[r-1][c-1] < m) m = run[r-1][c-1];
                    run[r][c] = m + 1;
                end
                if (run[r][c] > best) best = run[r][c];
            end
        end
        return best[lus_pkg::DIM_W-1:0];
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = lus_pkg::DIM_W'(64);
            cols_reg = lus_pkg::DIM_W'(64);
            row_pos  = 0;
            col_pos  = 0;
            expected_sides.delete();
            o_pending = 0;
        end else begin
            // Match the result item first, so a stray one never pairs with a fresh image
            if (i_out_valid && i_out_ready) begin
                if (expected_sides.size() == 0) begin
                    $error("largest_side: no result expected, got %0d", i_largest_side);
                    o_fail_count++;
                end else begin
                    want = expected_sides.pop_front();
                    if (i_largest_side !== want) begin
                        $error("largest_side: expected %0d, got %0d", want, i_largest_side);
                        o_fail_count++;
                    end
                end
            end

            // Known indexes update a dimension and restart the load, others are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == lus_pkg::REG_NUM_ROWS) begin
                    rows_reg = i_cfg_data;
                    row_pos  = 0;
                    col_pos  = 0;
                end else if (i_cfg_index == lus_pkg::REG_NUM_COLS) begin
                    cols_reg = i_cfg_data;
                    row_pos  = 0;
                    col_pos  = 0;
                end
            end

            // Store the pixel, advance in raster order, search after the last one
            if (i_in_valid && i_in_ready) begin
                rows_used = dim_in_use(rows_reg, lus_pkg::MAX_ROWS);
                cols_used = dim_in_use(cols_reg, lus_pkg::MAX_COLS);
                if (row_pos >= rows_used || col_pos >= cols_used) begin
                    row_pos = 0;
                    col_pos = 0;
                end
                image[row_pos][col_pos] = i_pixel;
                col_pos++;
                if (col_pos >= cols_used) begin
                    col_pos = 0;
                    row_pos++;
                end
                if (row_pos >= rows_used) begin
                    row_pos = 0;
                    expected_sides.insert(expected_sides.size(),
                                          largest_square(rows_used, cols_used));
                end
            end

            o_pending = expected_sides.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the largest_uniform_square bench: clock, reset, image stimulus and the verdict.
// Depends on lus_pkg, the block itself and lus_checker, which does all the checking.

module tb_top;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PIXELS = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;

    // Indexes past the register list, which the block must drop
    localparam logic [lus_pkg::CFG_I_W-1:0] REG_SPARE_LO = lus_pkg::CFG_I_W'(2);
    localparam logic [lus_pkg::CFG_I_W-1:0] REG_SPARE_HI = lus_pkg::CFG_I_W'(3);

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [lus_pkg::CFG_I_W-1:0] cfg_index;
    logic [lus_pkg::DIM_W-1:0]   cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        pixel;
    logic                        out_valid;
    logic                        out_ready;
    logic [lus_pkg::DIM_W-1:0]   largest_side;

    int fail_count;
    int pending;
    int src_idle_pct = 32;
    int dst_idle_pct = 71;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int cycles       = 0;

    largest_uniform_square dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_pixel        (pixel),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_largest_side (largest_side)
    );

    lus_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_pixel        (pixel),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_largest_side (largest_side),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    function automatic int eff_dim(input logic [lus_pkg::DIM_W-1:0] v, input int lim);
        if (v == '0) return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Offer one pixel after random idle cycles, hold it until accepted
    task automatic send_pixel(input logic px);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [lus_pkg::CFG_I_W-1:0] idx,
                             input logic [lus_pkg::DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pixel i of the image is bit i of the pattern
    task automatic send_bits(input int count, input logic [63:0] bits);
        for (int i = 0; i < count; i++) send_pixel(bits[i]);
    endtask

    // Random image with a planted single-valued square
    task automatic send_image(input int rows, input int cols, input int ones_pct,
                              input int side, input int r0, input int c0, input logic val);
        logic px;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (r >= r0 && r < r0 + side && c >= c0 && c < c0 + side) begin
                    px = val;
                end else begin
                    px = ($urandom_range(0, 99) < ones_pct);
                end
                send_pixel(px);
            end
        end
    endtask

    // Stop offering and wait until every owed item has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        logic [lus_pkg::DIM_W-1:0] rows_raw;
        logic [lus_pkg::DIM_W-1:0] cols_raw;
        int  rows, cols, n_imgs, phase, small_px, side, r0, c0, k;
        bit  pressed, extreme, press;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lus_pkg::REG_NUM_ROWS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: single pixels, spare indexes dropped, small images with known sides
        write_reg(lus_pkg::REG_NUM_ROWS, 7'd1);
        write_reg(lus_pkg::REG_NUM_COLS, 7'd1);
        write_reg(REG_SPARE_LO, 7'h55);
        write_reg(REG_SPARE_HI, 7'h2A);
        send_bits(1, 64'b0);
        send_bits(1, 64'b1);
        drain_results();
        write_reg(lus_pkg::REG_NUM_ROWS, 7'd2);
        write_reg(lus_pkg::REG_NUM_COLS, 7'd2);
        send_bits(4, 64'b1111);
        send_bits(4, 64'b0000);
        send_bits(4, 64'b1001);
        send_bits(4, 64'b1000);
        drain_results();
        write_reg(lus_pkg::REG_NUM_COLS, 7'd3);
        send_bits(6, 64'b110110);

        // Random phases: one setting each, a few images per setting
        phase    = 0;
        small_px = 0;
        pressed  = 0;
        while (small_px < RANDOM_PIXELS || phase <= 8 || !pressed) begin
            drain_results();
            if (small_px < RANDOM_PIXELS / 3) begin
                src_idle_pct = 32;
                dst_idle_pct = 71;
            end else if (small_px < 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 71;
                dst_idle_pct = 32;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end

            extreme = (phase == 2 || phase == 5 || phase == 8);
            press   = !extreme && !pressed && src_idle_pct == 0;
            n_imgs  = $urandom_range(1, 4);
            if (phase == 2) begin
                rows_raw = 7'd0;
                cols_raw = 7'd127;
                n_imgs   = 2;
            end else if (phase == 5) begin
                rows_raw = 7'd127;
                cols_raw = 7'd0;
                n_imgs   = 2;
            end else if (phase == 8) begin
                rows_raw = 7'd24;
                cols_raw = 7'd24;
                n_imgs   = 1;
            end else if (press) begin
                rows_raw = 7'd3;
                cols_raw = 7'd3;
                n_imgs   = 8;
            end else begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    rows_raw = lus_pkg::DIM_W'($urandom_range(1, 8));
                    cols_raw = lus_pkg::DIM_W'($urandom_range(1, 8));
                end else if (k < 8) begin
                    rows_raw = lus_pkg::DIM_W'($urandom_range(1, 3));
                    cols_raw = lus_pkg::DIM_W'($urandom_range(9, 64));
                end else begin
                    rows_raw = $urandom_range(0, 1) ? '0 :
                               lus_pkg::DIM_W'($urandom_range(65, 127));
                    cols_raw = lus_pkg::DIM_W'($urandom_range(1, 6));
                end
                if ($urandom_range(0, 1)) {rows_raw, cols_raw} = {cols_raw, rows_raw};
            end

            write_reg(lus_pkg::REG_NUM_ROWS, rows_raw);
            write_reg(lus_pkg::REG_NUM_COLS, cols_raw);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          lus_pkg::DIM_W'($urandom));
            end
            rows = eff_dim(rows_raw, lus_pkg::MAX_ROWS);
            cols = eff_dim(cols_raw, lus_pkg::MAX_COLS);

            // Stall results long enough for the next searches to back up into the input
            if (press) begin
                hold_reqs++;
                pressed = 1;
            end

            for (int i = 0; i < n_imgs; i++) begin
                if (phase == 8) begin
                    // Large image: big corner square keeps the search short
                    send_image(24, 24, 50, 20, 0, 0, 1'($urandom_range(0, 1)));
                end else begin
                    side = $urandom_range(0, (rows < cols) ? rows : cols);
                    r0   = $urandom_range(0, rows - side);
                    c0   = $urandom_range(0, cols - side);
                    send_image(rows, cols, 25 * $urandom_range(0, 4), side, r0, c0,
                               1'($urandom_range(0, 1)));
                end
            end
            if (!extreme) small_px += n_imgs * rows * cols;
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
